// ===== src/pcg32_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_pkg
// Types, constants and helper functions of the PCG32 bounded random unit.
// ----------------------------------------------------------------------------
package pcg32_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned DivCntW = 6;

  // SplitMix64 seed mixing
  localparam logic [WordW-1:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

  // LCG step
  localparam logic [WordW-1:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [WordW-1:0] LCG_INC = 64'd1;

  // divider iteration counts (last index)
  localparam logic [DivCntW-1:0] DIV_LAST_SMALL = 6'd31;
  localparam logic [DivCntW-1:0] DIV_LAST_LARGE = 6'd63;

  typedef enum logic [KindW-1:0] {
    KIND_DRAW32  = 2'd0,
    KIND_DRAW64  = 2'd1,
    KIND_BOUNDED = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_MIX0,
    S_MUL_MIXA,
    S_MUL_MIXB,
    S_IDLE,
    S_DIV_THR,
    S_DRAW,
    S_MUL_LCG,
    S_NEXT,
    S_DIV_VAL,
    S_DONE
  } state_e;

  // XSH-RR output permutation of the pre-step state
  function automatic logic [HalfW-1:0] xsh_rr(input logic [WordW-1:0] s);
    logic [WordW-1:0] mixed;
    logic [HalfW-1:0] x;
    logic [4:0]       rot;
    logic [WordW-1:0] dbl;
    mixed = ((s >> 18) ^ s) >> 27;
    x     = mixed[HalfW-1:0];
    rot   = s[63:59];
    dbl   = {x, x} >> rot;
    return dbl[HalfW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/pcg32_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_req_if
// Request channel: valid/ready handshake with request kind and bound.
// ----------------------------------------------------------------------------
interface pcg32_req_if
  import pcg32_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [WordW-1:0] bound;

  modport source (output valid, output kind, output bound, input ready);
  modport sink   (input valid, input kind, input bound, output ready);
endinterface
`default_nettype wire

// ===== src/pcg32_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_rsp_if
// Result channel: valid/ready handshake with random value and error flag.
// ----------------------------------------------------------------------------
interface pcg32_rsp_if
  import pcg32_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] value;
  logic             bad_bound;

  modport source (output valid, output value, output bad_bound, input ready);
  modport sink   (input valid, input value, input bad_bound, output ready);
endinterface
`default_nettype wire

// ===== src/pcg32_bounded_random_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_bounded_random_generator_unit
// PCG32 XSH-RR generator with SplitMix64 seeding and rejection-sampled
// bounded draws, built around one 32x32 multiplier and one radix-2 divider.
// ----------------------------------------------------------------------------
// Each 32-bit draw steps the LCG state on the shared 32x32 multiplier; 64-bit
//   items and bounded items with bounds of 2^32 or more take two draws per word.
// Bounded item: two remainders on the bit-serial divider (a 32-bit one for bounds
//   below 2^32, a 64-bit one otherwise) plus the candidate draws, redrawn on rejection.
// One item at a time; the result register holds until taken.
// Reset and every seed write run the seed mix; no item accepted meanwhile.
module pcg32_bounded_random_generator_unit
  import pcg32_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WordW-1:0] cfg_wdata_i,
  pcg32_req_if.sink             req_i,
  pcg32_rsp_if.source           rsp_o
);

  state_e state_q, state_d;

  logic [WordW-1:0]   seed_q, seed_d;
  logic [WordW-1:0]   gen_q, gen_d;
  kind_e              kind_q, kind_d;
  logic [WordW-1:0]   bound_q, bound_d;
  logic               small_q, small_d;
  logic               two_q, two_d;
  logic               second_q, second_d;
  logic [WordW-1:0]   w_q, w_d;
  logic [WordW-1:0]   thr_q, thr_d;
  logic [WordW-1:0]   value_q, value_d;
  logic               bad_q, bad_d;

  // shared multiplier
  logic [WordW-1:0]   op_a_q, op_a_d;
  logic [WordW-1:0]   op_b_q, op_b_d;
  logic [WordW-1:0]   pp_q, pp_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [1:0]         mcnt_q, mcnt_d;
  logic [HalfW-1:0]   mul_x, mul_y;
  logic [WordW-1:0]   mul_res;
  logic               mul_last;

  // shared divider
  logic [WordW-1:0]   rem_q, rem_d;
  logic [WordW-1:0]   n_q, n_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [WordW:0]     div_trial;
  logic               div_ge;
  logic [WordW:0]     div_diff;
  logic [WordW-1:0]   div_rem;
  logic               div_last;

  logic               req_fire;
  logic               in_small;
  logic [WordW-1:0]   mix_z;
  logic [WordW-1:0]   cand;
  logic               cand_low;
  logic               need_more;

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = (state_q == S_DONE);
  assign rsp_o.value     = value_q;
  assign rsp_o.bad_bound = bad_q;

  assign req_fire  = req_i.valid && (state_q == S_IDLE);
  assign in_small  = (req_i.bound[WordW-1:HalfW] == '0);
  assign mix_z     = seed_q + MIX_GAMMA;
  assign need_more = two_q && !second_q;
  assign cand      = small_q ? {{HalfW{1'b0}}, w_q[HalfW-1:0]} : w_q;
  assign cand_low  = (cand < thr_q);

  // low 64 bits of op_a * op_b from three 32x32 partial products
  always_comb begin
    unique case (mcnt_q)
      2'd0:    begin mul_x = op_a_q[HalfW-1:0];     mul_y = op_b_q[HalfW-1:0];     end
      2'd1:    begin mul_x = op_a_q[HalfW-1:0];     mul_y = op_b_q[WordW-1:HalfW]; end
      2'd2:    begin mul_x = op_a_q[WordW-1:HalfW]; mul_y = op_b_q[HalfW-1:0];     end
      default: begin mul_x = '0;                    mul_y = '0;                    end
    endcase
  end

  assign pp_d     = mul_x * mul_y;
  assign mul_res  = acc_q + {pp_q[HalfW-1:0], {HalfW{1'b0}}};
  assign mul_last = (mcnt_q == 2'd3);

  // restoring remainder, one bit per cycle
  assign div_trial = {rem_q, n_q[WordW-1]};
  assign div_ge    = (div_trial >= {1'b0, bound_q});
  assign div_diff  = div_trial - {1'b0, bound_q};
  assign div_rem   = div_ge ? div_diff[WordW-1:0] : div_trial[WordW-1:0];
  assign div_last  = (dcnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_MIX0:     state_d = S_MUL_MIXA;
      S_MUL_MIXA: if (mul_last) state_d = S_MUL_MIXB;
      S_MUL_MIXB: if (mul_last) state_d = S_IDLE;
      S_IDLE: begin
        if (req_fire) begin
          case (kind_e'(req_i.kind))
            KIND_DRAW32, KIND_DRAW64: state_d = S_DRAW;
            KIND_BOUNDED: state_d = (req_i.bound == '0) ? S_DONE : S_DIV_THR;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_DIV_THR:  if (div_last) state_d = S_DRAW;
      S_DRAW:     state_d = S_MUL_LCG;
      S_MUL_LCG:  if (mul_last) state_d = S_NEXT;
      S_NEXT: begin
        if (need_more) begin
          state_d = S_DRAW;
        end else if (kind_q == KIND_BOUNDED) begin
          state_d = cand_low ? S_DRAW : S_DIV_VAL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_VAL:  if (div_last) state_d = S_DONE;
      S_DONE:     if (rsp_o.ready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
    // a seed write restarts the mix from the new seed
    if (cfg_we_i) state_d = S_MIX0;
  end

  // datapath
  always_comb begin
    seed_d   = seed_q;
    gen_d    = gen_q;
    kind_d   = kind_q;
    bound_d  = bound_q;
    small_d  = small_q;
    two_d    = two_q;
    second_d = second_q;
    w_d      = w_q;
    thr_d    = thr_q;
    value_d  = value_q;
    bad_d    = bad_q;
    op_a_d   = op_a_q;
    op_b_d   = op_b_q;
    acc_d    = (mcnt_q == 2'd1) ? pp_q : mul_res;
    mcnt_d   = mcnt_q;
    rem_d    = rem_q;
    n_d      = n_q;
    dcnt_d   = dcnt_q;

    unique case (state_q)
      S_MIX0: begin
        op_a_d = mix_z ^ (mix_z >> 30);
        op_b_d = MIX_MUL_A;
        mcnt_d = '0;
      end
      S_MUL_MIXA: begin
        mcnt_d = mcnt_q + 2'd1;
        if (mul_last) begin
          op_a_d = mul_res ^ (mul_res >> 27);
          op_b_d = MIX_MUL_B;
        end
      end
      S_MUL_MIXB: begin
        mcnt_d = mcnt_q + 2'd1;
        if (mul_last) gen_d = mul_res ^ (mul_res >> 31);
      end
      S_IDLE: begin
        if (req_fire) begin
          kind_d   = kind_e'(req_i.kind);
          bound_d  = req_i.bound;
          small_d  = in_small;
          two_d    = (kind_e'(req_i.kind) == KIND_DRAW64) ||
                     ((kind_e'(req_i.kind) == KIND_BOUNDED) && !in_small);
          second_d = 1'b0;
          value_d  = '0;
          bad_d    = (kind_e'(req_i.kind) == KIND_BOUNDED) && (req_i.bound == '0);
          // threshold = (2^N - bound) mod bound
          rem_d    = '0;
          if (in_small) begin
            n_d    = {(HalfW'(0) - req_i.bound[HalfW-1:0]), {HalfW{1'b0}}};
            dcnt_d = DIV_LAST_SMALL;
          end else begin
            n_d    = '0 - req_i.bound;
            dcnt_d = DIV_LAST_LARGE;
          end
        end
      end
      S_DIV_THR: begin
        rem_d  = div_rem;
        n_d    = n_q << 1;
        dcnt_d = dcnt_q - 1'b1;
        if (div_last) thr_d = div_rem;
      end
      S_DRAW: begin
        w_d    = {w_q[HalfW-1:0], xsh_rr(gen_q)};
        op_a_d = gen_q;
        op_b_d = LCG_MUL;
        mcnt_d = '0;
      end
      S_MUL_LCG: begin
        mcnt_d = mcnt_q + 2'd1;
        if (mul_last) gen_d = mul_res + LCG_INC;
      end
      S_NEXT: begin
        second_d = need_more;
        if (!need_more) begin
          case (kind_q)
            KIND_DRAW32: value_d = {{HalfW{1'b0}}, w_q[HalfW-1:0]};
            KIND_DRAW64: value_d = w_q;
            KIND_BOUNDED: begin
              if (!cand_low) begin
                rem_d = '0;
                if (small_q) begin
                  n_d    = {cand[HalfW-1:0], {HalfW{1'b0}}};
                  dcnt_d = DIV_LAST_SMALL;
                end else begin
                  n_d    = cand;
                  dcnt_d = DIV_LAST_LARGE;
                end
              end
            end
            default: value_d = '0;
          endcase
        end
      end
      S_DIV_VAL: begin
        rem_d  = div_rem;
        n_d    = n_q << 1;
        dcnt_d = dcnt_q - 1'b1;
        if (div_last) value_d = div_rem;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase

    if (cfg_we_i) seed_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_MIX0;
      seed_q   <= '0;
      second_q <= 1'b0;
      mcnt_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      seed_q   <= seed_d;
      second_q <= second_d;
      mcnt_q   <= mcnt_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gen_q   <= gen_d;
    kind_q  <= kind_d;
    bound_q <= bound_d;
    small_q <= small_d;
    two_q   <= two_d;
    w_q     <= w_d;
    thr_q   <= thr_d;
    value_q <= value_d;
    bad_q   <= bad_d;
    op_a_q  <= op_a_d;
    op_b_q  <= op_b_d;
    pp_q    <= pp_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    n_q     <= n_d;
  end

endmodule
`default_nettype wire

// ===== sim/tb_pcg32_bounded_random_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcg32_bounded_random_generator_unit
// Self-checking bench for the PCG32 bounded random unit. A behavioral model
// of the generator (SplitMix64 seeding, XSH-RR output, rejection-sampled
// bounded draws) predicts every result. Results are checked in order against
// the prediction, across seed changes, random idling on both channels, a
// long result stall and back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_pcg32_bounded_random_generator_unit;
  import pcg32_pkg::*;

  localparam int unsigned NO_ACTIVITY_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES     = 300;
  localparam int unsigned RSP_HOLD_CYCLES   = 300;

  // generator constants, kept separate from the design's own copies
  localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] PCG_MUL  = 64'd6364136223846793005;
  localparam logic [63:0] PCG_INC  = 64'd1;

  typedef struct packed {
    logic [63:0] value;
    logic        bad_bound;
  } draw_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;

  pcg32_req_if req_ch ();
  pcg32_rsp_if rsp_ch ();

  pcg32_bounded_random_generator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // model state
  logic [63:0]  model_seed;
  logic [63:0]  model_gen;
  draw_result_t pending_draws[$];

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned n_draw32, n_draw64, n_bounded, n_zero_bound, n_seed_writes;
  int unsigned idle_cycles;
  int unsigned rsp_hold_left;
  bit          no_idling;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] splitmix(input logic [63:0] s);
    logic [63:0] z;
    z = s + SM_GAMMA;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  // output permutation of the old state, then advance the LCG
  function automatic logic [31:0] model_next32();
    logic [63:0] prev;
    logic [63:0] folded;
    logic [31:0] x;
    logic [4:0]  rot;
    prev      = model_gen;
    model_gen = prev * PCG_MUL + PCG_INC;
    folded    = ((prev >> 18) ^ prev) >> 27;
    x         = folded[31:0];
    rot       = prev[63:59];
    return (x >> rot) | (x << ((6'd32 - {1'b0, rot}) & 6'd31));
  endfunction

  function automatic logic [63:0] model_next64();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = model_next32();
    lo = model_next32();
    return {hi, lo};
  endfunction

  function automatic logic [63:0] model_draw_below(input logic [63:0] limit);
    logic [31:0] lim32;
    logic [31:0] thr32;
    logic [31:0] r32;
    logic [63:0] thr64;
    logic [63:0] r64;
    if (limit <= 64'h0000_0000_FFFF_FFFF) begin
      lim32 = limit[31:0];
      thr32 = (32'd0 - lim32) % lim32;
      do r32 = model_next32(); while (r32 < thr32);
      return {32'd0, r32 % lim32};
    end
    thr64 = (64'd0 - limit) % limit;
    do r64 = model_next64(); while (r64 < thr64);
    return r64 % limit;
  endfunction

  function automatic draw_result_t predict_draw(input kind_e k, input logic [63:0] limit);
    draw_result_t r;
    r = '0;
    case (k)
      KIND_DRAW32: r.value = {32'd0, model_next32()};
      KIND_DRAW64: r.value = model_next64();
      KIND_BOUNDED: begin
        if (limit == 64'd0) r.bad_bound = 1'b1;
        else r.value = model_draw_below(limit);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: ready pattern and in-order checking
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rsp_hold_left > 0) begin
      rsp_ch.ready  <= 1'b0;
      rsp_hold_left <= rsp_hold_left - 1;
    end else if (!no_idling && $urandom_range(99) < 8) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  draw_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_draws.size() == 0) begin
        $error("result with nothing pending: value %h bad_bound %b",
               rsp_ch.value, rsp_ch.bad_bound);
        error_count++;
      end else begin
        want = pending_draws.pop_front();
        if (rsp_ch.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp_ch.value);
          error_count++;
        end
        if (rsp_ch.bad_bound !== want.bad_bound) begin
          $error("bad_bound: expected %b, got %b", want.bad_bound, rsp_ch.bad_bound);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= NO_ACTIVITY_LIMIT) begin
      $display("timeout: no activity for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------
  task automatic send_request(input kind_e k, input logic [63:0] limit);
    @(negedge clk_i);
    // random idle cycles before offering the item
    while (!no_idling && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.bound <= limit;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    pending_draws.push_back(predict_draw(k, limit));
    case (k)
      KIND_DRAW32: n_draw32++;
      KIND_DRAW64: n_draw64++;
      default: begin
        n_bounded++;
        if (limit == 64'd0) n_zero_bound++;
      end
    endcase
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] s);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_seed = s;
    model_gen  = splitmix(s);
    n_seed_writes++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_bound();
    logic [63:0] b;
    case ($urandom_range(9))
      0: b = $urandom_range(1, 16);
      1: b = {32'd0, $urandom} | 64'd1;
      2: b = 64'h8000_0000 + $urandom_range(0, 255);
      3: b = 64'h1_0000_0000 - $urandom_range(1, 255);
      4: b = 64'h1_0000_0000 + $urandom_range(0, 255);
      5: b = rand64();
      6: b = 64'h8000_0000_0000_0000 + $urandom_range(0, 255);
      7: b = 64'd1 << $urandom_range(63);
      8: b = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 255);
      default: b = 64'd0;
    endcase
    return b;
  endfunction

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) send_request(KIND_DRAW32, rand64());
    else if (pick < 50) send_request(KIND_DRAW64, rand64());
    else send_request(KIND_BOUNDED, pick_bound());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // edge cases of each kind under the reset seed
  task automatic test_directed_kinds();
    send_request(KIND_DRAW32, 64'd0);
    send_request(KIND_DRAW32, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_DRAW64, 64'd0);
    send_request(KIND_DRAW64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_BOUNDED, 64'd0);                     // zero bound flags error
    send_request(KIND_BOUNDED, 64'd1);
    send_request(KIND_BOUNDED, 64'd2);
    send_request(KIND_BOUNDED, 64'd3);
    send_request(KIND_BOUNDED, 64'd7);
    send_request(KIND_BOUNDED, 64'h8000_0001);             // heavy 32-bit rejection
    send_request(KIND_BOUNDED, 64'hFFFF_FFFF);             // largest small bound
    send_request(KIND_BOUNDED, 64'h1_0000_0000);           // smallest large bound
    send_request(KIND_BOUNDED, 64'h1_0000_0001);
    send_request(KIND_BOUNDED, 64'h8000_0000_0000_0000);
    send_request(KIND_BOUNDED, 64'h8000_0000_0000_0001);   // heavy 64-bit rejection
    send_request(KIND_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_BOUNDED, 64'd0);
    send_request(KIND_DRAW32, 64'h5555_5555_5555_5555);
    drain();
  endtask

  task automatic test_seed_extremes();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_request(KIND_DRAW32, 64'd0);
    send_request(KIND_DRAW64, 64'd0);
    send_request(KIND_BOUNDED, 64'd10);
    drain();
    write_seed(64'd0);
    send_request(KIND_DRAW64, 64'd0);
    send_request(KIND_BOUNDED, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_back_to_back();
    no_idling = 1'b1;
    write_seed(rand64());
    repeat (40) send_random_request();
    drain();
    no_idling = 1'b0;
  endtask

  // hold the result channel so the unit fills and stalls its input
  task automatic test_result_stall();
    rsp_hold_left = RSP_HOLD_CYCLES;
    repeat (5) send_random_request();
    drain();
  endtask

  task automatic test_random_seeds();
    logic [63:0] seeds[6];
    seeds = '{64'd1, 64'h8000_0000_0000_0000, rand64(), 64'hFFFF_FFFF_FFFF_FFFF,
              rand64(), 64'd0};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      repeat (25) send_random_request();
      drain();   // sender pauses until all results are back
      repeat (30) send_random_request();
      drain();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    req_ch.valid  = 1'b0;
    req_ch.kind   = KIND_DRAW32;
    req_ch.bound  = '0;
    rsp_ch.ready  = 1'b0;
    error_count   = 0;
    results_seen  = 0;
    n_draw32      = 0;
    n_draw64      = 0;
    n_bounded     = 0;
    n_zero_bound  = 0;
    n_seed_writes = 0;
    idle_cycles   = 0;
    rsp_hold_left = 0;
    no_idling     = 1'b0;
    model_seed    = '0;
    model_gen     = splitmix(64'd0);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_kinds();
    test_seed_extremes();
    test_back_to_back();
    test_result_stall();
    test_random_seeds();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_draws.size() != 0) begin
      $error("%0d results never arrived", pending_draws.size());
      error_count++;
    end

    $display("covered %0d results: %0d draw32, %0d draw64, %0d bounded (%0d zero bound)",
             results_seen, n_draw32, n_draw64, n_bounded, n_zero_bound);
    $display("over %0d seed writes, with idling, a long result stall and back-to-back items",
             n_seed_writes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pcg32_pkg.sv
src/pcg32_req_if.sv
src/pcg32_rsp_if.sv
src/pcg32_bounded_random_generator_unit.sv
sim/tb_pcg32_bounded_random_generator_unit.sv
